// File: hdl/u8d_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
// Used by the front, the back and the top level; depends on nothing.

package u8d_pkg;

    localparam int OFFSET_BITS       = 32;
    localparam int CP_BITS           = 21;
    localparam int POSITION_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ST_BAD_CONT  = 3'd2;
    localparam logic [2:0] ST_BAD_CP    = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;
    localparam logic [2:0] ST_AFTER_ERR = 3'd5;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_INVALID
    } byte_class_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_t;

    typedef struct packed {
        logic [CP_BITS-1:0]     code_point;
        logic [OFFSET_BITS-1:0] seq_offset;
        logic [2:0]             seq_length;
        logic [2:0]             status;
        logic                   final_res;
    } result_t;

    // A classified byte on its way from the front to the back.
    typedef struct packed {
        byte_class_t            cls;
        logic [7:0]             data;
        logic                   fin;
        logic [OFFSET_BITS-1:0] offset;
    } mid_item_t;

endpackage

// File: hdl/u8d_fifo.sv
// Small first-in first-out queue of flip-flops with push/full and pop/empty.
// Generic in width and depth; depends on nothing else.

module u8d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/u8d_front.sv
// Front of the decoder: takes text bytes, classifies each one and stamps its offset.
// Depends on u8d_pkg for the item types.

module u8d_front
    import u8d_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  text_t     text,
    output logic      full,
    output logic      mid_push,
    output mid_item_t mid_item,
    input  logic      mid_full
);

    logic [POSITION_BITS-1:0] position_reg;
    logic [POSITION_BITS-1:0] position_next;
    logic [OFFSET_BITS-1:0]   offset;
    byte_class_t              cls;
    logic                     accept;

    assign full     = mid_full;
    assign accept   = push && !mid_full;
    assign mid_push = accept;

    always_comb
    begin
        unique case (text.text_byte) inside
            [8'h00:8'h7F]: cls = CLS_ASCII;
            [8'h80:8'hBF]: cls = CLS_CONT;
            [8'hC0:8'hDF]: cls = CLS_LEAD2;
            [8'hE0:8'hEF]: cls = CLS_LEAD3;
            [8'hF0:8'hF7]: cls = CLS_LEAD4;
            default:       cls = CLS_INVALID;
        endcase
    end

    // The reported offset is the low part of the position count, or the count zero-extended when it is narrower.
    generate
        if (POSITION_BITS >= OFFSET_BITS)
        begin : g_off_trunc
            assign offset = position_reg[OFFSET_BITS-1:0];
        end
        else
        begin : g_off_ext
            assign offset = {{(OFFSET_BITS - POSITION_BITS){1'b0}}, position_reg};
        end
    endgenerate

    assign mid_item.cls    = cls;
    assign mid_item.data   = text.text_byte;
    assign mid_item.fin    = text.end_of_text;
    assign mid_item.offset = offset;

    always_comb
    begin
        position_next = position_reg;
        if (accept)
        begin
            position_next = text.end_of_text ? '0 : position_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

endmodule

// File: hdl/u8d_back.sv
// Back of the decoder: runs the sequence state over classified bytes and forms results.
// Depends on u8d_pkg for the item types and status codes.

module u8d_back
    import u8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mid_item_t mid_item,
    input  logic      mid_empty,
    output logic      mid_pop,
    output logic      out_push,
    output result_t   out_item,
    input  logic      out_full
);

    localparam logic [CP_BITS-1:0] MIN_CP2   = 21'h00080;
    localparam logic [CP_BITS-1:0] MIN_CP3   = 21'h00800;
    localparam logic [CP_BITS-1:0] MIN_CP4   = 21'h10000;
    localparam logic [CP_BITS-1:0] MAX_CP    = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] SURR_LOW  = 21'h0D800;
    localparam logic [CP_BITS-1:0] SURR_HIGH = 21'h0DFFF;

    logic [CP_BITS-1:0]     partial_reg;
    logic [CP_BITS-1:0]     partial_next;
    logic [2:0]             exp_len_reg;
    logic [2:0]             exp_len_next;
    logic [2:0]             rcv_reg;
    logic [2:0]             rcv_next;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [OFFSET_BITS-1:0] start_next;
    logic                   err_reg;
    logic                   err_next;

    logic                   step;
    logic                   has_res;
    logic [CP_BITS-1:0]     cp_new;
    logic [2:0]             rcv_inc;
    logic                   overlong;
    logic                   bad_cp;

    assign step    = !mid_empty && !out_full;
    assign mid_pop = step;
    assign out_push = step && has_res;

    assign cp_new  = {partial_reg[CP_BITS-7:0], mid_item.data[5:0]};
    assign rcv_inc = rcv_reg + 3'd1;

    assign overlong = ((exp_len_reg == 3'd2) && (cp_new < MIN_CP2)) ||
                      ((exp_len_reg == 3'd3) && (cp_new < MIN_CP3)) ||
                      ((exp_len_reg == 3'd4) && (cp_new < MIN_CP4));
    assign bad_cp   = overlong || (cp_new > MAX_CP) ||
                      ((cp_new >= SURR_LOW) && (cp_new <= SURR_HIGH));

    always_comb
    begin
        partial_next = partial_reg;
        exp_len_next = exp_len_reg;
        rcv_next     = rcv_reg;
        start_next   = start_reg;
        err_next     = err_reg;
        has_res      = 1'b0;
        out_item.code_point = '0;
        out_item.seq_offset = mid_item.offset;
        out_item.seq_length = '0;
        out_item.status     = ST_OK;
        out_item.final_res  = mid_item.fin;

        if (err_reg)
        begin
            // After an error only the last byte produces a result.
            has_res         = mid_item.fin;
            out_item.status = ST_AFTER_ERR;
        end
        else if (exp_len_reg == 3'd0)
        begin
            unique case (mid_item.cls)
                CLS_ASCII:
                begin
                    has_res             = 1'b1;
                    out_item.code_point = {{(CP_BITS - 7){1'b0}}, mid_item.data[6:0]};
                    out_item.seq_length = 3'd1;
                end
                CLS_LEAD2, CLS_LEAD3, CLS_LEAD4:
                begin
                    rcv_next        = 3'd1;
                    start_next      = mid_item.offset;
                    has_res         = mid_item.fin;
                    out_item.status = ST_TRUNC;
                    if (mid_item.cls == CLS_LEAD2)
                    begin
                        exp_len_next = 3'd2;
                        partial_next = {{(CP_BITS - 5){1'b0}}, mid_item.data[4:0]};
                    end
                    else if (mid_item.cls == CLS_LEAD3)
                    begin
                        exp_len_next = 3'd3;
                        partial_next = {{(CP_BITS - 4){1'b0}}, mid_item.data[3:0]};
                    end
                    else
                    begin
                        exp_len_next = 3'd4;
                        partial_next = {{(CP_BITS - 3){1'b0}}, mid_item.data[2:0]};
                    end
                end
                default:
                begin
                    has_res         = 1'b1;
                    err_next        = 1'b1;
                    out_item.status = ST_BAD_LEAD;
                end
            endcase
        end
        else if (mid_item.cls != CLS_CONT)
        begin
            has_res         = 1'b1;
            err_next        = 1'b1;
            exp_len_next    = 3'd0;
            out_item.status = ST_BAD_CONT;
        end
        else
        begin
            partial_next        = cp_new;
            rcv_next            = rcv_inc;
            out_item.seq_offset = start_reg;
            if (rcv_inc >= exp_len_reg)
            begin
                has_res      = 1'b1;
                exp_len_next = 3'd0;
                rcv_next     = 3'd0;
                partial_next = '0;
                if (bad_cp)
                begin
                    err_next        = 1'b1;
                    out_item.status = ST_BAD_CP;
                end
                else
                begin
                    out_item.code_point = cp_new;
                    out_item.seq_length = exp_len_reg;
                end
            end
            else
            begin
                has_res         = mid_item.fin;
                out_item.status = ST_TRUNC;
            end
        end

        // The last byte of a text returns the decoder to its reset state.
        if (mid_item.fin)
        begin
            partial_next = '0;
            exp_len_next = 3'd0;
            rcv_next     = 3'd0;
            start_next   = '0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            exp_len_reg <= '0;
            rcv_reg     <= '0;
            start_reg   <= '0;
            err_reg     <= 1'b0;
        end
        else if (step)
        begin
            partial_reg <= partial_next;
            exp_len_reg <= exp_len_next;
            rcv_reg     <= rcv_next;
            start_reg   <= start_next;
            err_reg     <= err_next;
        end
    end

endmodule

// File: hdl/utf8_validating_decoder_top.sv
// UTF-8 validating decoder, one text byte per cycle while full is low.
// Text bytes enter through push/full with the last byte of a text flagged.
// Results leave through empty/pop; the oldest result sits on result while
// empty is low and is taken at an edge with pop high.
// Each byte is classified and stamped with its offset in the front and
// queued; the back runs the sequence state and writes results to an output
// queue. An accepted byte passes the middle queue and then the output queue,
// both registered, before its result, if any, can be popped.
// Throughput is one byte per cycle while the output queue is not full, set
// by the single decode step of the back stage; bytes inside an unfinished
// sequence and bytes after an error, the last byte apart, produce no result.
// The first error is reported once with its offset; the last byte always
// yields one final result, and the decoder returns to its reset state after it.
// Reset empties both queues and clears the position count and all sequence
// state. When the receiver stops popping, the output queue fills, the back
// stalls, the middle queue fills and full rises; nothing is dropped.
// Depends on u8d_pkg, u8d_fifo, u8d_front and u8d_back.

module utf8_validating_decoder_top
    import u8d_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  text_t   text,
    output logic    full,
    input  logic    pop,
    output result_t result,
    output logic    empty
);

    localparam int MID_W = $bits(mid_item_t);
    localparam int OUT_W = $bits(result_t);

    logic             mid_push;
    mid_item_t        mid_in;
    logic             mid_full;
    logic             mid_pop;
    logic [MID_W-1:0] mid_rdata;
    logic             mid_empty;
    logic             out_push;
    result_t          out_in;
    logic             out_full;
    logic [OUT_W-1:0] out_rdata;

    u8d_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .text     (text),
        .full     (full),
        .mid_push (mid_push),
        .mid_item (mid_in),
        .mid_full (mid_full)
    );

    u8d_fifo #(
        .WIDTH(MID_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_in),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    u8d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_item  (mid_item_t'(mid_rdata)),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_push  (out_push),
        .out_item  (out_in),
        .out_full  (out_full)
    );

    u8d_fifo #(
        .WIDTH(OUT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign result = result_t'(out_rdata);

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("back stage wrote a result into a full output queue");

    a_ok_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == ST_OK) |->
            (result.seq_length >= 3'd1 && result.seq_length <= 3'd4 &&
             result.code_point <= 21'h10FFFF))
        else $error("ok result with bad length or code point");

    a_err_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != ST_OK) |->
            (result.code_point == '0 && result.seq_length == 3'd0))
        else $error("error result carries a code point or length");

    a_after_err_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.status == ST_AFTER_ERR || result.status == ST_TRUNC)) |->
            result.final_res)
        else $error("end-after-error or truncation result not marked final");
`endif

endmodule
